// ----- src/bfc_pkg.sv -----
// bfc_pkg: constants, types and codes shared by the block feature classifier
// used by bfc_ctrl, bfc_datapath and block_feature_classifier_unit
package bfc_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int FRAC_BITS  = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CNT_W      = 23;
  localparam int DIM_W      = 12;
  localparam int LBL_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int MA_W       = 28;
  localparam int MB_W       = 16;
  localparam int PW         = MA_W + MB_W;
  localparam int OUT_W      = 112;

  localparam logic [7:0] BLACK_LIMIT = 8'd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXT_HEIGHT = 3'd0,
    CFG_THX_BOUNDS  = 3'd1,
    CFG_THX_LINE    = 3'd2,
    CFG_ASPECT      = 3'd3,
    CFG_LINE_TRANS  = 3'd4,
    CFG_TVX_LARGE   = 3'd5,
    CFG_DENSITY     = 3'd6
  } cfg_idx_t;

  typedef enum logic [LBL_W-1:0] {
    LBL_TEXT    = 3'd0,
    LBL_LARGE   = 3'd1,
    LBL_SMALL   = 3'd2,
    LBL_HLINE   = 3'd3,
    LBL_VLINE   = 3'd4,
    LBL_GRAPHIC = 3'd5,
    LBL_PICTURE = 3'd6
  } label_t;

  typedef enum logic [3:0] {
    MUL_CH1X  = 4'd0,
    MUL_CH2X  = 4'd1,
    MUL_CH3X  = 4'd2,
    MUL_CRH   = 4'd3,
    MUL_C3X   = 4'd4,
    MUL_C4X   = 4'd5,
    MUL_THCH3 = 4'd6,
    MUL_WCR   = 4'd7,
    MUL_C3H   = 4'd8,
    MUL_C4H   = 4'd9,
    MUL_CV1X  = 4'd10,
    MUL_CV2X  = 4'd11,
    MUL_C5W   = 4'd12,
    MUL_NWH   = 4'd13
  } mul_op_t;

  localparam int NUM_OPS = 14;

  typedef struct packed {
    logic    upd;
    logic    mul;
    mul_op_t op;
    logic    load;
    logic    sweep;
  } cmd_t;

  typedef struct packed {
    logic eob;
    logic sweep_last;
    logic out_busy;
  } status_t;

endpackage

// ----- src/bfc_ctrl.sv -----
// bfc_ctrl: sequencer for pixel update, product steps, result load and clearing sweep
// depends on bfc_pkg
module bfc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  bfc_pkg::status_t status,
  output bfc_pkg::cmd_t    cmd
);
  import bfc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MUL,
    ST_DECIDE,
    ST_CLEAR
  } state_t;

  state_t  state;
  mul_op_t op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      op    <= MUL_CH1X;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          op <= MUL_CH1X;
          state <= status.eob ? ST_MUL : ST_IDLE;
        end
        ST_MUL: begin
          if (op == MUL_NWH) state <= ST_DECIDE;
          else op <= mul_op_t'(op + 4'd1);
        end
        ST_DECIDE: begin
          if (!status.out_busy) state <= ST_CLEAR;
        end
        ST_CLEAR: begin
          if (status.sweep_last) state <= ST_IDLE;
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  always_comb begin
    s_tready  = (state == ST_IDLE);
    cmd.upd   = (state == ST_UPDATE);
    cmd.mul   = (state == ST_MUL);
    cmd.op    = op;
    cmd.load  = (state == ST_DECIDE) && !status.out_busy;
    cmd.sweep = (state == ST_CLEAR);
  end

endmodule

// ----- src/bfc_datapath.sv -----
// bfc_datapath: row buffer, column marks, feature counters, shared multiplier,
// rule chain and output register; depends on bfc_pkg
module bfc_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [7:0]                    gray,
  input  logic                          eor_in,
  input  logic                          eob_in,
  input  logic                          cfg_we,
  input  logic [bfc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [31:0]                   cfg_wdata,
  input  bfc_pkg::cmd_t                 cmd,
  output bfc_pkg::status_t              status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bfc_pkg::OUT_W-1:0]     out_data
);
  import bfc_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [DIM_W-1:0] DIM_MAX = {DIM_W{1'b1}};

  logic [31:0] text_height_bounds, th_x_bounds, line_transition_bounds, tv_x_large_bounds;
  logic [15:0] th_x_line_limit, aspect_limit, density_limit;

  logic row_mem [MAX_WIDTH];
  logic col_mem [MAX_WIDTH];
  logic row_rd, col_rd;
  logic black_r, eor_r, eob_r;

  logic             left_pixel;
  logic [CNT_W-1:0] black_total, horiz_total, vert_total;
  logic [DIM_W-1:0] black_column_total, row_width, blk_w, blk_h;
  logic [COL_W-1:0] column_index, max_col, sweep;
  logic [ROW_W-1:0] row_index;

  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [PW-1:0]   prod [NUM_OPS];

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      text_height_bounds     <= '0;
      th_x_bounds            <= '0;
      th_x_line_limit        <= '0;
      aspect_limit           <= '0;
      line_transition_bounds <= '0;
      tv_x_large_bounds      <= '0;
      density_limit          <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TEXT_HEIGHT: text_height_bounds     <= cfg_wdata;
        CFG_THX_BOUNDS:  th_x_bounds            <= cfg_wdata;
        CFG_THX_LINE:    th_x_line_limit        <= cfg_wdata[15:0];
        CFG_ASPECT:      aspect_limit           <= cfg_wdata[15:0];
        CFG_LINE_TRANS:  line_transition_bounds <= cfg_wdata;
        CFG_TVX_LARGE:   tv_x_large_bounds      <= cfg_wdata;
        CFG_DENSITY:     density_limit          <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // row buffer and column marks
  always_ff @(posedge clk) begin
    if (accept) begin
      row_rd <= row_mem[column_index];
      col_rd <= col_mem[column_index];
    end
    if (cmd.upd) row_mem[column_index] <= black_r;
    if (cmd.sweep) col_mem[sweep] <= 1'b0;
    else if (cmd.upd && black_r) col_mem[column_index] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      black_r <= (gray <= BLACK_LIMIT);
      eor_r   <= eor_in;
      eob_r   <= eob_in;
    end
  end

  // feature counters
  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel         <= 1'b0;
      black_total        <= '0;
      horiz_total        <= '0;
      vert_total         <= '0;
      black_column_total <= '0;
      column_index       <= '0;
      row_index          <= '0;
      row_width          <= '0;
      max_col            <= COL_W'(MAX_WIDTH - 1);
      sweep              <= '0;
    end else if (cmd.upd) begin
      if (black_r) begin
        if (black_total != CNT_MAX) black_total <= black_total + 1'b1;
        if (column_index != '0 && !left_pixel && horiz_total != CNT_MAX)
          horiz_total <= horiz_total + 1'b1;
        if (row_index != '0 && !row_rd && vert_total != CNT_MAX)
          vert_total <= vert_total + 1'b1;
        if (!col_rd) begin
          if (black_column_total != DIM_MAX)
            black_column_total <= black_column_total + 1'b1;
          if (column_index > max_col) max_col <= column_index;
        end
      end
      left_pixel <= black_r;
      if (eob_r) begin
        blk_w <= (row_index == '0) ? DIM_W'(column_index) + DIM_W'(1) : row_width;
        blk_h <= DIM_W'(row_index) + DIM_W'(1);
      end else if (eor_r) begin
        if (row_index == '0) row_width <= DIM_W'(column_index) + DIM_W'(1);
        if (row_index != ROW_W'(MAX_HEIGHT - 1)) row_index <= row_index + 1'b1;
        column_index <= '0;
        left_pixel   <= 1'b0;
      end else if (column_index != COL_W'(MAX_WIDTH - 1)) begin
        column_index <= column_index + 1'b1;
      end
    end else if (cmd.load) begin
      left_pixel         <= 1'b0;
      black_total        <= '0;
      horiz_total        <= '0;
      vert_total         <= '0;
      black_column_total <= '0;
      column_index       <= '0;
      row_index          <= '0;
      row_width          <= '0;
    end else if (cmd.sweep) begin
      if (sweep == max_col) begin
        sweep   <= '0;
        max_col <= '0;
      end else begin
        sweep <= sweep + 1'b1;
      end
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      MUL_CH1X:  begin mul_a = MA_W'(black_column_total); mul_b = th_x_bounds[15:0]; end
      MUL_CH2X:  begin mul_a = MA_W'(black_column_total); mul_b = th_x_bounds[31:16]; end
      MUL_CH3X:  begin mul_a = MA_W'(black_column_total); mul_b = th_x_line_limit; end
      MUL_CRH:   begin mul_a = MA_W'(blk_h); mul_b = aspect_limit; end
      MUL_C3X:   begin
        mul_a = MA_W'(black_column_total); mul_b = line_transition_bounds[15:0];
      end
      MUL_C4X:   begin
        mul_a = MA_W'(black_column_total); mul_b = line_transition_bounds[31:16];
      end
      MUL_THCH3: begin mul_a = MA_W'(horiz_total); mul_b = th_x_line_limit; end
      MUL_WCR:   begin mul_a = MA_W'(blk_w); mul_b = aspect_limit; end
      MUL_C3H:   begin mul_a = MA_W'(blk_h); mul_b = line_transition_bounds[15:0]; end
      MUL_C4H:   begin mul_a = MA_W'(blk_h); mul_b = line_transition_bounds[31:16]; end
      MUL_CV1X:  begin mul_a = MA_W'(black_column_total); mul_b = tv_x_large_bounds[15:0]; end
      MUL_CV2X:  begin mul_a = MA_W'(black_column_total); mul_b = tv_x_large_bounds[31:16]; end
      MUL_C5W:   begin mul_a = MA_W'(blk_w); mul_b = density_limit; end
      MUL_NWH:   begin mul_a = prod[MUL_C5W][MA_W-1:0]; mul_b = MB_W'(blk_h); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) prod[cmd.op] <= PW'(mul_a) * PW'(mul_b);
  end

  // rule chain
  logic [PW-1:0] s_th, s_tv, s_w, s_h, s_x, s_n;
  logic [15:0]   lo, hi;
  logic          hasx, thx_text, is_text, is_small, is_hline, is_vline, is_large, is_graphic;
  label_t        label;

  always_comb begin
    s_th = PW'(horiz_total) << FRAC_BITS;
    s_tv = PW'(vert_total) << FRAC_BITS;
    s_w  = PW'(blk_w) << FRAC_BITS;
    s_h  = PW'(blk_h) << FRAC_BITS;
    s_x  = PW'(black_column_total) << FRAC_BITS;
    s_n  = PW'(black_total) << 16;
    lo   = text_height_bounds[15:0];
    hi   = text_height_bounds[31:16];
    hasx = (black_column_total != '0);
    thx_text = hasx && prod[MUL_CH1X] < s_th && s_th < prod[MUL_CH2X];
    is_text  = (16'(blk_h) > lo) && (16'(blk_h) < hi);
    is_small = (16'(blk_h) < lo) && thx_text;
    is_hline = hasx && s_th < prod[MUL_CH3X] && s_w > prod[MUL_CRH]
               && prod[MUL_C3X] < s_tv && s_tv < prod[MUL_C4X];
    is_vline = hasx && prod[MUL_THCH3] > s_x && prod[MUL_WCR] < s_h
               && prod[MUL_C3H] < s_th && s_th < prod[MUL_C4H];
    is_large = (16'(blk_h) > hi) && thx_text
               && prod[MUL_CV1X] < s_tv && s_tv < prod[MUL_CV2X];
    is_graphic = s_n < prod[MUL_NWH];
    if (is_text)         label = LBL_TEXT;
    else if (is_small)   label = LBL_SMALL;
    else if (is_hline)   label = LBL_HLINE;
    else if (is_vline)   label = LBL_VLINE;
    else if (is_large)   label = LBL_LARGE;
    else if (is_graphic) label = LBL_GRAPHIC;
    else                 label = LBL_PICTURE;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data <= {4'b0, blk_h, blk_w, black_column_total, vert_total, horiz_total,
                   black_total, label};
    end
  end

  always_comb begin
    status.eob        = eob_r;
    status.sweep_last = (sweep == max_col);
    status.out_busy   = out_valid && !out_ready;
  end

endmodule

// ----- src/block_feature_classifier_unit.sv -----
// block_feature_classifier_unit: top level of the block feature classifier
// sequence: each pixel word is accepted, then the row buffer and counters are updated;
// the last pixel adds 14 product steps on the shared multiplier, a decision step that waits
// while the output is busy, and a clearing sweep of column marks 0 to the highest marked one
// reset: synchronous; after reset a sweep of all 2048 column marks runs before the first
// pixel is taken; config writes are taken at any time
module block_feature_classifier_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // gray_pixel
  input  logic                          s_tlast,  // end_of_block
  input  logic                          s_tuser,  // end_of_row
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // block_label, black_count, horiz_transitions, vert_transitions, black_columns,
  // block_width, block_height, zero pad
  output logic [bfc_pkg::OUT_W-1:0]     m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import bfc_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  bfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bfc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .accept    (s_tvalid && s_tready),
    .gray      (s_tdata),
    .eor_in    (s_tuser),
    .eob_in    (s_tlast),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

  a_one_pixel: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("pixel taken while previous one in update");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> m_tvalid)
    else $error("result load did not raise output valid");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !(cmd.sweep || cmd.mul || cmd.upd))
    else $error("input ready during block work");

  a_label_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] != 3'd7)
    else $error("label code out of range");

endmodule
